/* rtl/core/key_press_classifier_fifo_top_assert.svh */
// ----------------------------------------------------------------------------
// Key press classifier assertion macros
// Shared property forms for the key press classifier checker.
// ----------------------------------------------------------------------------
`ifndef KEY_PRESS_CLASSIFIER_FIFO_TOP_ASSERT_SVH
`define KEY_PRESS_CLASSIFIER_FIFO_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle, idle in reset
`define KPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle, idle in reset
`define KPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle, checked through reset
`define KPC_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/kpc_pkg.sv */
// ----------------------------------------------------------------------------
// Key press classifier package
// Sizes, register map, reset values and status codes of the classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int KEY_W      = 4;
  localparam int STATUS_W   = 3;
  localparam int LIMIT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_CODE    = 2'd0,
    CFG_SHORT_LIMIT  = 2'd1,
    CFG_LONG_LIMIT   = 2'd2,
    CFG_REPEAT_LIMIT = 2'd3
  } cfg_reg_t;

  localparam logic [KEY_W-1:0]   IDLE_CODE_RST    = 4'd15;
  localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST  = 16'd3;
  localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST   = 16'd100;
  localparam logic [LIMIT_W-1:0] REPEAT_LIMIT_RST = 16'd20;

  localparam logic [STATUS_W-1:0] STATUS_IDLE = 3'd0;

endpackage

/* rtl/core/key_press_classifier_fifo_top.sv */
// ----------------------------------------------------------------------------
// Key press classifier with record FIFO
// Classifies held key codes and queues short, long and repeat reports.
// ----------------------------------------------------------------------------
// Every accepted item, scan tick or pop, yields exactly one result in the next
// cycle, and a new item is taken every cycle while in_ready is high: the
// classifier state, the hold counter and the FIFO pointers are all updated in
// the single cycle of the transfer. The result sits in an output register;
// in_ready drops only while that register holds a result that out_ready has
// not yet taken. The record store is FIFO_DEPTH flip-flop entries that read
// as undefined until written. Configuration writes are accepted in any cycle.
module key_press_classifier_fifo_top
  import kpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [KEY_W-1:0]      in_key_bits,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_read_ok,
  output logic [KEY_W-1:0]      out_key,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_pushed,
  output logic                  out_dropped
);

  typedef enum logic [STATUS_W-1:0] {
    PH_IDLE     = 3'd0,
    PH_DETECTED = 3'd1,
    PH_SHORT    = 3'd2,
    PH_LONG     = 3'd3,
    PH_REPEAT   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [STATUS_W-1:0] status;
  } record_t;

  logic [KEY_W-1:0]    idle_code_r;
  logic [LIMIT_W-1:0]  short_limit_r;
  logic [LIMIT_W-1:0]  long_limit_r;
  logic [LIMIT_W-1:0]  repeat_limit_r;

  phase_t              phase_r, phase_nxt;
  logic [KEY_W-1:0]    held_r, held_nxt;
  logic [LIMIT_W-1:0]  count_r, count_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  record_t             store_r [FIFO_DEPTH];

  logic                out_valid_r;
  logic                read_ok_r, read_ok_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                pushed_r, pushed_nxt;
  logic                dropped_r, dropped_nxt;

  logic                accept;
  logic                push_en;
  logic [LIMIT_W-1:0]  count_inc;
  logic [LIMIT_W-1:0]  limit;
  phase_t              step_phase;
  logic                step_ok;

  assign cfg_ready   = 1'b1;
  assign in_ready    = !out_valid_r || out_ready;
  assign accept      = in_valid && in_ready;

  assign out_valid   = out_valid_r;
  assign out_read_ok = read_ok_r;
  assign out_key     = key_r;
  assign out_status  = status_r;
  assign out_pushed  = pushed_r;
  assign out_dropped = dropped_r;

  assign count_inc = count_r + LIMIT_W'(1);

  always_comb begin
    limit      = repeat_limit_r;
    step_phase = PH_REPEAT;
    step_ok    = 1'b1;
    case (phase_r)
      PH_DETECTED: begin
        limit      = short_limit_r;
        step_phase = PH_SHORT;
      end
      PH_SHORT: begin
        limit      = long_limit_r;
        step_phase = PH_LONG;
      end
      PH_LONG, PH_REPEAT: begin
        limit      = repeat_limit_r;
        step_phase = PH_REPEAT;
      end
      default: step_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    count_nxt   = count_r;
    rd_ptr_nxt  = rd_ptr_r;
    wr_ptr_nxt  = wr_ptr_r;
    fill_nxt    = fill_r;
    push_en     = 1'b0;
    read_ok_nxt = 1'b0;
    key_nxt     = idle_code_r;
    status_nxt  = STATUS_IDLE;
    pushed_nxt  = 1'b0;
    dropped_nxt = 1'b0;

    if (in_req_type) begin
      if (fill_r != '0) begin
        read_ok_nxt = 1'b1;
        key_nxt     = store_r[rd_ptr_r].key;
        status_nxt  = store_r[rd_ptr_r].status;
        rd_ptr_nxt  = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
        fill_nxt    = fill_r - CNT_W'(1);
      end
    end else if (in_key_bits == idle_code_r) begin
      held_nxt  = idle_code_r;
      phase_nxt = PH_IDLE;
    end else if (phase_r == PH_IDLE || held_r != in_key_bits) begin
      held_nxt  = in_key_bits;
      phase_nxt = PH_DETECTED;
      count_nxt = '0;
    end else if (step_ok) begin
      count_nxt = count_inc;
      if (count_inc >= limit) begin
        phase_nxt = step_phase;
        count_nxt = '0;
        if (fill_r < CNT_W'(FIFO_DEPTH)) begin
          push_en    = 1'b1;
          pushed_nxt = 1'b1;
          wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
          fill_nxt   = fill_r + CNT_W'(1);
        end else begin
          dropped_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_code_r    <= IDLE_CODE_RST;
      short_limit_r  <= SHORT_LIMIT_RST;
      long_limit_r   <= LONG_LIMIT_RST;
      repeat_limit_r <= REPEAT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDLE_CODE:    idle_code_r    <= cfg_data[KEY_W-1:0];
        CFG_SHORT_LIMIT:  short_limit_r  <= cfg_data[LIMIT_W-1:0];
        CFG_LONG_LIMIT:   long_limit_r   <= cfg_data[LIMIT_W-1:0];
        CFG_REPEAT_LIMIT: repeat_limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      held_r      <= '0;
      count_r     <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        held_r      <= held_nxt;
        count_r     <= count_nxt;
        rd_ptr_r    <= rd_ptr_nxt;
        wr_ptr_r    <= wr_ptr_nxt;
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      read_ok_r <= read_ok_nxt;
      key_r     <= key_nxt;
      status_r  <= status_nxt;
      pushed_r  <= pushed_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push_en) begin
      store_r[wr_ptr_r] <= '{key: held_r, status: step_phase};
    end
  end

endmodule

/* rtl/core/kpc_checker.sv */
// ----------------------------------------------------------------------------
// Key press classifier checker
// Port-level properties of the classifier result channel.
// ----------------------------------------------------------------------------
`include "key_press_classifier_fifo_top_assert.svh"

module kpc_checker
  import kpc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_read_ok,
  input logic [KEY_W-1:0]    out_key,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_pushed,
  input logic                out_dropped
);

  `KPC_ASSERT_NEXT_RST(a_reset_empty, !rst_n, !out_valid, "result valid after reset")
  `KPC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable({out_read_ok, out_key, out_status, out_pushed, out_dropped}), "stalled result changed")
  `KPC_ASSERT_SAME(a_pop_no_push, out_valid && out_read_ok, !out_pushed && !out_dropped, "pop result flags a push")
  `KPC_ASSERT_SAME(a_push_xor_drop, out_valid, !(out_pushed && out_dropped), "record both stored and lost")
  `KPC_ASSERT_SAME(a_no_record_idle, out_valid && !out_read_ok, out_status == STATUS_IDLE, "status set without a popped record")

endmodule

bind key_press_classifier_fifo_top kpc_checker u_kpc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_read_ok (out_read_ok),
  .out_key     (out_key),
  .out_status  (out_status),
  .out_pushed  (out_pushed),
  .out_dropped (out_dropped)
);
